>>> hw/rtl/tspq_pkg.sv
// Shared types, codes and the ordering function of the timestamp priority queue.
package tspq_pkg;

	// Number of cells in the queue and the width of the fill counter.
	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Fixed field widths of the command and result ports.
	localparam int TIME_W  = 16;
	localparam int ID_W    = 8;
	localparam int ENTRY_W = 5;
	localparam int ERR_W   = 2;

	// Command codes.
	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Error codes.
	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

	// One stored request.
	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [ID_W-1:0]   id;
	} pair_t;

	// Per-cycle operation broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic rel;
	} cell_ctl_t;

	// True when the stored pair sorts strictly after the new pair.
	function automatic logic sorts_after(input pair_t held, input pair_t fresh);
		logic res;
		if (held.stamp != fresh.stamp) begin
			res = held.stamp > fresh.stamp;
		end else begin
			res = held.id > fresh.id;
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/tspq_cell.sv
// One cell of the sorted shift-register queue.
module tspq_cell (
	input  logic               clk,
	input  tspq_pkg::cell_ctl_t ctl,
	input  logic               occ,
	input  tspq_pkg::pair_t    new_pair,
	input  logic               prev_after,
	input  tspq_pkg::pair_t    prev_pair,
	input  tspq_pkg::pair_t    next_pair,
	output tspq_pkg::pair_t    pair,
	output logic               after
);
	import tspq_pkg::*;

	pair_t pair_q;
	pair_t pair_d;

	// An empty cell counts as sorting after any new pair, so the insert lands at the tail.
	assign after = !occ || sorts_after(pair_q, new_pair);
	assign pair  = pair_q;

	// Insert: the first cell that sorts after takes the new pair, later ones shift right.
	// Release: every cell but the last takes its right neighbour; the last keeps its own pair.
	always_comb begin
		pair_d = pair_q;
		if (ctl.ins && after) begin
			pair_d = prev_after ? prev_pair : new_pair;
		end else if (ctl.rel) begin
			pair_d = next_pair;
		end
	end

	// Payload storage needs no reset.
	always_ff @(posedge clk) begin
		pair_q <= pair_d;
	end

endmodule

>>> hw/rtl/timestamp_priority_queue.sv
// Top level of the timestamp priority queue: command port, cell chain and result registers.
//
// A command is transferred at a rising edge where start is high and busy is low. cmd selects
// an insert of (req_time, req_id) or a release of the smallest stored pair. busy is held low:
// the chain of cells never stalls a command, so a command can follow every cycle.
// The result appears in the cycle after the transfer, with done high for exactly that cycle:
// head_valid, head_time and head_id describe the smallest pair after the command (zero when
// the queue is empty), entry_count the number of stored pairs, and err_code reports an insert
// into a full queue or a release from an empty one; such commands leave the store unchanged.
// Throughput is one command per cycle, as every cell updates at the same edge,
// each comparing its own pair with the new one in parallel.
// Pairs sort by timestamp and then by id; a pair equal to stored ones goes behind them.
// Reset empties the queue and clears done and err_code; the pair storage itself is not cleared.
// The receiver cannot stall: each result must be taken in the cycle that done is high.
module timestamp_priority_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cmd,
	input  logic [tspq_pkg::TIME_W-1:0] req_time,
	input  logic [tspq_pkg::ID_W-1:0]   req_id,
	output logic                        done,
	output logic                        head_valid,
	output logic [tspq_pkg::TIME_W-1:0] head_time,
	output logic [tspq_pkg::ID_W-1:0]   head_id,
	output logic [tspq_pkg::ENTRY_W-1:0] entry_count,
	output logic [tspq_pkg::ERR_W-1:0]  err_code
);
	import tspq_pkg::*;

	logic             accept;
	cell_ctl_t        ctl;
	pair_t            new_pair;
	pair_t            cell_pair  [QUEUE_DEPTH];
	logic             cell_after [QUEUE_DEPTH];
	logic [CNT_W-1:0] fill_q;
	logic             done_q;
	logic [ERR_W-1:0] err_q;

	// Command transfer and the operation broadcast to the cells.
	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign new_pair = '{stamp: req_time, id: req_id};
	assign ctl.ins  = accept && (cmd == CMD_INSERT) && (fill_q != CNT_W'(QUEUE_DEPTH));
	assign ctl.rel  = accept && (cmd == CMD_RELEASE) && (fill_q != '0);

	// The chain of cells, slot 0 holding the smallest pair.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic  prev_after;
		pair_t prev_pair;
		pair_t next_pair;

		if (i == 0) begin : g_first
			assign prev_after = 1'b0;
			assign prev_pair  = new_pair;
		end else begin : g_mid
			assign prev_after = cell_after[i-1];
			assign prev_pair  = cell_pair[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_pair = cell_pair[i];
		end else begin : g_inner
			assign next_pair = cell_pair[i+1];
		end

		tspq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (IDX < fill_q),
			.new_pair   (new_pair),
			.prev_after (prev_after),
			.prev_pair  (prev_pair),
			.next_pair  (next_pair),
			.pair       (cell_pair[i]),
			.after      (cell_after[i])
		);
	end

	// Fill count, result strobe and error code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
			err_q  <= ERR_NONE;
		end else begin
			done_q <= accept;
			if (ctl.ins) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (ctl.rel) begin
				fill_q <= fill_q - CNT_W'(1);
			end
			if (accept) begin
				if (cmd == CMD_INSERT) begin
					err_q <= ctl.ins ? ERR_NONE : ERR_FULL;
				end else begin
					err_q <= ctl.rel ? ERR_NONE : ERR_EMPTY;
				end
			end
		end
	end

	// Result ports read the state left by the last transferred command.
	assign done        = done_q;
	assign head_valid  = (fill_q != '0);
	assign head_time   = head_valid ? cell_pair[0].stamp : '0;
	assign head_id     = head_valid ? cell_pair[0].id : '0;
	assign entry_count = ENTRY_W'(fill_q);
	assign err_code    = err_q;

`ifndef NO_ASSERTIONS
	// The fill count never passes the number of cells.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(QUEUE_DEPTH))
		else $error("fill count exceeds queue depth");

	// Every transferred command gives exactly one result in the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result strobe missing after a command");

	// A refused command leaves the fill count unchanged and reports an error code.
	a_refused_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ctl.ins && !ctl.rel) |=> ($stable(fill_q) && err_code != ERR_NONE))
		else $error("refused command changed the queue");

	// The two smallest stored pairs are in order.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q > CNT_W'(1)) |-> !sorts_after(cell_pair[0], cell_pair[1]))
		else $error("head pair out of order");
`endif

endmodule
